[hw/rtl/rgbgs_pkg.sv]
package rgbgs_pkg;

    localparam int CHAN_W    = 8;
    localparam int GAIN_W    = 16;
    localparam int PB_W      = 3;
    localparam int NUM_CH    = 3;
    localparam int PROD_W    = CHAN_W + GAIN_W;
    localparam int REM_W     = 2 * CHAN_W;
    localparam int DIV_STEPS = CHAN_W;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(255);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
    localparam logic [PB_W-1:0]   PB_RESET   = PB_W'(3);
    localparam logic [PB_W-1:0]   RGB_BYTES  = PB_W'(3);
    // largest product that still fits a channel: 255 * 256
    localparam logic [PROD_W-1:0] NORM_LIMIT = PROD_W'(255 * 256);

    typedef enum logic
    {
        REG_GAIN   = 1'b0,
        REG_PBYTES = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [REM_W-1:0]  rem;
        logic [CHAN_W-1:0] quo;
        logic [CHAN_W-1:0] res;
    } lane_t;

    typedef struct packed
    {
        logic                     last;
        logic                     norm;
        logic [CHAN_W-1:0]        den;
        lane_t [NUM_CH-1:0]       lane;
    } stage_t;

endpackage

[hw/rtl/rgbgs_in_if.sv]
interface rgbgs_in_if import rgbgs_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic              last_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output last_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input last_in, output ready);

endinterface

[hw/rtl/rgbgs_out_if.sv]
interface rgbgs_out_if import rgbgs_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              last_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output last_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input last_out, output ready);

endinterface

[hw/rtl/rgb_gamma_scale_normalize.sv]
// Pipeline: an accepted request passes 1 multiply stage, 1 select stage and
//   8 restoring-division stages, one quotient bit each, in that order.
// Throughput: one pixel per cycle; a stall at the output freezes the whole pipe.
// Reset (rst_n low, async): pipeline valid bits clear, gain returns to 1.0
//   (256), bytes per pixel to 3. Data registers are not reset.
module rgb_gamma_scale_normalize import rgbgs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rgbgs_in_if.sink          pix_in,
    rgbgs_out_if.source       pix_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [PB_W-1:0]   pb_reg, pb_next;
    reg_idx_t          cfg_idx;
    logic              cfg_wr;

    // registers sit at byte addresses 0 and 4; bit 2 picks one
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        gain_next = gain_reg;
        pb_next   = pb_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GAIN:   gain_next = pwdata[GAIN_W-1:0];
                REG_PBYTES: pb_next   = pwdata[PB_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GAIN:   prdata = DATA_W'(gain_reg);
            REG_PBYTES: prdata = DATA_W'(pb_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            pb_reg   <= PB_RESET;
        end
        else
        begin
            gain_reg <= gain_next;
            pb_reg   <= pb_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless the result in
    // the output register is held by the consumer.
    // ------------------------------------------------------------------
    logic en;

    assign en           = !pix_out.valid || pix_out.ready;
    assign pix_in.ready = en;

    // ------------------------------------------------------------------
    // Stage 0: gain multiply and channel maximum
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] chan_in [NUM_CH];
    logic [CHAN_W-1:0] cmax_in;

    logic              m_vld_reg;
    logic [PROD_W-1:0] m_prod_reg [NUM_CH];
    logic [CHAN_W-1:0] m_chan_reg [NUM_CH];
    logic [CHAN_W-1:0] m_cmax_reg;
    logic              m_pass_reg;
    logic              m_last_reg;

    always_comb
    begin
        chan_in[0] = pix_in.red_in;
        chan_in[1] = pix_in.green_in;
        chan_in[2] = pix_in.blue_in;
        cmax_in    = chan_in[0];
        if (chan_in[1] > cmax_in)
        begin
            cmax_in = chan_in[1];
        end
        if (chan_in[2] > cmax_in)
        begin
            cmax_in = chan_in[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_CH; k++)
            begin
                m_prod_reg[k] <= PROD_W'(chan_in[k]) * PROD_W'(gain_reg);
                m_chan_reg[k] <= chan_in[k];
            end
            m_cmax_reg <= cmax_in;
            // fewer than three bytes per pixel: pass the pixel through
            m_pass_reg <= (pb_reg < RGB_BYTES);
            m_last_reg <= pix_in.last_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decide on normalization, form dividends c*255 and the
    // plain scaled result
    // ------------------------------------------------------------------
    stage_t sel_next;
    logic   over;

    always_comb
    begin
        // the largest product exceeds the limit iff any product does
        over = 1'b0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            over = over || (m_prod_reg[k] > NORM_LIMIT);
        end
        sel_next.last = m_last_reg;
        sel_next.norm = over && !m_pass_reg;
        sel_next.den  = m_cmax_reg;
        for (int k = 0; k < NUM_CH; k++)
        begin
            sel_next.lane[k].rem = {m_chan_reg[k], CHAN_W'(0)} - REM_W'(m_chan_reg[k]);
            sel_next.lane[k].quo = '0;
            // without normalization every product is at most 255*256
            sel_next.lane[k].res = m_pass_reg ? m_chan_reg[k]
                                              : m_prod_reg[k][2*CHAN_W-1:CHAN_W];
        end
    end

    // ------------------------------------------------------------------
    // Stages 2..9: restoring division c*255 / cmax, one quotient bit per
    // stage, most significant first. The quotient never exceeds 255 since
    // c <= cmax. The last stage also picks the final channel value.
    // ------------------------------------------------------------------
    logic   st_vld_reg [DIV_STEPS+1];
    stage_t st_reg     [DIV_STEPS+1];
    stage_t div_next   [DIV_STEPS];

    always_comb
    begin
        logic [REM_W-1:0] trial;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            div_next[s] = st_reg[s];
            for (int k = 0; k < NUM_CH; k++)
            begin
                trial = REM_W'(st_reg[s].den) << (DIV_STEPS - 1 - s);
                if (st_reg[s].lane[k].rem >= trial)
                begin
                    div_next[s].lane[k].rem = st_reg[s].lane[k].rem - trial;
                    div_next[s].lane[k].quo[DIV_STEPS-1-s] = 1'b1;
                end
                if ((s == DIV_STEPS - 1) && st_reg[s].norm)
                begin
                    div_next[s].lane[k].res = div_next[s].lane[k].quo;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                st_vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            st_vld_reg[0] <= m_vld_reg;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                st_vld_reg[s+1] <= st_vld_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= sel_next;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                st_reg[s+1] <= div_next[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result: the last division stage is the output register
    // ------------------------------------------------------------------
    assign pix_out.valid     = st_vld_reg[DIV_STEPS];
    assign pix_out.red_out   = st_reg[DIV_STEPS].lane[0].res;
    assign pix_out.green_out = st_reg[DIV_STEPS].lane[1].res;
    assign pix_out.blue_out  = st_reg[DIV_STEPS].lane[2].res;
    assign pix_out.last_out  = st_reg[DIV_STEPS].last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // normalization only happens with a nonzero largest channel
    a_norm_den: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && st_reg[DIV_STEPS].norm) |-> (st_reg[DIV_STEPS].den != '0))
        else $error("normalized pixel with zero channel maximum");

    // finished division leaves every remainder below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && st_reg[DIV_STEPS].norm) |->
        ((st_reg[DIV_STEPS].lane[0].rem < REM_W'(st_reg[DIV_STEPS].den)) &&
         (st_reg[DIV_STEPS].lane[1].rem < REM_W'(st_reg[DIV_STEPS].den)) &&
         (st_reg[DIV_STEPS].lane[2].rem < REM_W'(st_reg[DIV_STEPS].den))))
        else $error("division remainder not below divisor");

    // a normalized pixel has its largest channel at full scale
    a_norm_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && st_reg[DIV_STEPS].norm) |->
        ((pix_out.red_out == CHAN_MAX) || (pix_out.green_out == CHAN_MAX) ||
         (pix_out.blue_out == CHAN_MAX)))
        else $error("normalized pixel without a full-scale channel");

endmodule

[sim/rgb_gamma_scale_normalize_test.sv]
`timescale 1ns / 100ps

module rgb_gamma_scale_normalize_test import rgbgs_pkg::*; ();

    localparam int REPORT_MAX  = 10;    // detailed reports before going quiet
    localparam int STALL_LIMIT = 5000;  // cycles without any handshake before giving up
    localparam int HOLD_CYCLES = 120;   // long output hold-off, well past pipe depth
    localparam int TAIL_CYCLES = 20;    // settle time after the last result
    localparam int PHASE_ITEMS = 178;   // random requests per configuration phase

    // One pixel, used for both requests and corrected results
    typedef struct packed
    {
        logic              last;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // Who idles: receiver heavy (34/71), sender heavy (71/34), nobody
    typedef enum logic [1:0]
    {
        RX_HEAVY,
        TX_HEAVY,
        NO_IDLE
    } idle_mode_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rgbgs_in_if  pix_in ();
    rgbgs_out_if pix_out ();

    rgb_gamma_scale_normalize DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Requests waiting for the driver, and corrected pixels waiting for the DUT
    pixel_t            request_q [$];
    pixel_t            corrected_q [$];
    pixel_t            offered;
    pixel_t            seen;
    pixel_t            want;

    // Shadow copies of the two registers, updated as each write lands
    logic [GAIN_W-1:0] gain_shadow;
    logic [PB_W-1:0]   pbytes_shadow;

    idle_mode_t        idle_mode;
    int unsigned       hold_asked;
    int unsigned       hold_granted;
    int unsigned       hold_left;
    int unsigned       fail_count;
    int unsigned       report_count;
    int unsigned       quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected correction of one pixel under the current register settings.
    // Below three bytes per pixel, pass the channels through. Otherwise scale by
    // the 8.8 gain, unless the brightest channel would overflow; then stretch
    // all channels so that the brightest lands exactly on full scale.
    function automatic pixel_t correct_pixel(pixel_t px);
        logic [CHAN_W-1:0] chan [NUM_CH];
        logic [CHAN_W-1:0] peak;
        logic [PROD_W-1:0] scaled;
        pixel_t            res;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        if (pbytes_shadow >= RGB_BYTES)
        begin
            peak = chan[0];
            for (int k = 1; k < NUM_CH; k++)
                if (chan[k] > peak)
                    peak = chan[k];
            // exactly 255 * 256 still counts as in range
            if (PROD_W'(peak) * PROD_W'(gain_shadow) > NORM_LIMIT)
            begin
                for (int k = 0; k < NUM_CH; k++)
                    chan[k] = CHAN_W'((REM_W'(chan[k]) * REM_W'(CHAN_MAX)) / REM_W'(peak));
            end
            else
            begin
                for (int k = 0; k < NUM_CH; k++)
                begin
                    scaled  = PROD_W'(chan[k]) * PROD_W'(gain_shadow);
                    chan[k] = scaled[CHAN_W +: CHAN_W];
                end
            end
        end
        res.red   = chan[0];
        res.green = chan[1];
        res.blue  = chan[2];
        res.last  = px.last;
        return res;
    endfunction

    // Random pixel, biased toward the interesting corners: the brightest channel
    // sitting right at or just past the overflow knee, gray pixels, and very
    // dark pixels that a large gain blows up.
    function automatic pixel_t random_pixel();
        logic [CHAN_W-1:0] chan [NUM_CH];
        int unsigned       pick;
        int unsigned       knee;
        int unsigned       peak;
        pixel_t            px;
        pick = $urandom_range(9);
        for (int k = 0; k < NUM_CH; k++)
            chan[k] = CHAN_W'($urandom_range(255));
        if (pick < 2 && gain_shadow > GAIN_RESET)
        begin
            // knee is at most 254 here, so peak stays a valid channel value
            knee = NORM_LIMIT / gain_shadow;
            peak = knee + $urandom_range(1);
            for (int k = 0; k < NUM_CH; k++)
                chan[k] = CHAN_W'($urandom_range(peak));
            chan[$urandom_range(NUM_CH - 1)] = CHAN_W'(peak);
        end
        else if (pick == 2)
        begin
            chan[1] = chan[0];
            chan[2] = chan[0];
        end
        else if (pick == 3)
        begin
            for (int k = 0; k < NUM_CH; k++)
                chan[k] = CHAN_W'($urandom_range(3));
        end
        px.red   = chan[0];
        px.green = chan[1];
        px.blue  = chan[2];
        px.last  = ($urandom_range(7) == 0);
        return px;
    endfunction

    function automatic bit sender_pauses();
        case (idle_mode)
            RX_HEAVY: return $urandom_range(99) < 34;
            TX_HEAVY: return $urandom_range(99) < 71;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pauses();
        case (idle_mode)
            RX_HEAVY: return $urandom_range(99) < 71;
            TX_HEAVY: return $urandom_range(99) < 34;
            default:  return 1'b0;
        endcase
    endfunction

    // Driver: on acceptance, predict the result of the request just taken;
    // whenever the slot is free, offer the next pending request or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_in.valid <= 1'b0;
        end
        else
        begin
            if (pix_in.valid && pix_in.ready)
                corrected_q.push_back(correct_pixel(offered));
            if (!pix_in.valid || pix_in.ready)
            begin
                if (request_q.size() != 0 && !sender_pauses())
                begin
                    offered = request_q.pop_front();
                    pix_in.valid    <= 1'b1;
                    pix_in.red_in   <= offered.red;
                    pix_in.green_in <= offered.green;
                    pix_in.blue_in  <= offered.blue;
                    pix_in.last_in  <= offered.last;
                end
                else
                begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction, then
    // pick the next ready. A hold-off request from the sequence wins over the
    // random idling and keeps ready low for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_out.ready <= 1'b0;
            hold_left     = 0;
        end
        else
        begin
            if (pix_out.valid && pix_out.ready)
            begin
                seen.red   = pix_out.red_out;
                seen.green = pix_out.green_out;
                seen.blue  = pix_out.blue_out;
                seen.last  = pix_out.last_out;
                if (corrected_q.size() == 0)
                begin
                    fail_count++;
                    if (report_count < REPORT_MAX)
                        $display("unexpected pixel: r=%0d g=%0d b=%0d last=%0b",
                                 seen.red, seen.green, seen.blue, seen.last);
                    report_count++;
                end
                else
                begin
                    want = corrected_q.pop_front();
                    if (seen.red !== want.red || seen.green !== want.green ||
                        seen.blue !== want.blue || seen.last !== want.last)
                    begin
                        fail_count++;
                        if (report_count < REPORT_MAX)
                            $display("pixel mismatch: expected r=%0d g=%0d b=%0d last=%0b, %s",
                                     want.red, want.green, want.blue, want.last,
                                     $sformatf("got r=%0d g=%0d b=%0d last=%0b",
                                               seen.red, seen.green, seen.blue, seen.last));
                        report_count++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end
            else if (hold_granted != hold_asked)
            begin
                hold_granted++;
                hold_left = HOLD_CYCLES - 1;
                pix_out.ready <= 1'b0;
            end
            else
            begin
                pix_out.ready <= !receiver_pauses();
            end
        end
    end

    // Watchdog: give up when no request and no result moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // Wait until every request is taken and every result has come back
    task automatic drain();
        do
            @(posedge clk);
        while (request_q.size() != 0 || pix_in.valid || corrected_q.size() != 0);
    endtask

    // Setup cycle, then access cycle; the register lands on the edge that
    // sees psel, penable, pwrite and pready all high.
    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN:   gain_shadow   = value[GAIN_W-1:0];
            REG_PBYTES: pbytes_shadow = value[PB_W-1:0];
            default:    ;
        endcase
    endtask

    // Let the pipe run dry, then reprogram both registers
    task automatic settle(input logic [GAIN_W-1:0] gain, input logic [PB_W-1:0] pbytes);
        drain();
        apb_write(REG_GAIN, DATA_W'(gain));
        apb_write(REG_PBYTES, DATA_W'(pbytes));
    endtask

    task automatic send(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                        input logic [CHAN_W-1:0] b, input logic last);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.last  = last;
        request_q.push_back(px);
    endtask

    task automatic run_phase(input logic [GAIN_W-1:0] gain, input logic [PB_W-1:0] pbytes,
                             input idle_mode_t mode, input bit hold);
        settle(gain, pbytes);
        idle_mode = mode;
        // ask for the long hold-off while the sender keeps offering requests
        if (hold)
            hold_asked++;
        repeat (PHASE_ITEMS)
            request_q.push_back(random_pixel());
    endtask

    initial
    begin
        // Drive every input to a known value from time zero
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pix_in.valid     = 1'b0;
        pix_in.red_in    = '0;
        pix_in.green_in  = '0;
        pix_in.blue_in   = '0;
        pix_in.last_in   = 1'b0;
        pix_out.ready    = 1'b0;
        gain_shadow      = GAIN_RESET;
        pbytes_shadow    = PB_RESET;
        idle_mode        = RX_HEAVY;
        hold_asked       = 0;
        hold_granted     = 0;
        fail_count       = 0;
        report_count     = 0;
        quiet_cycles     = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: unity gain, three bytes per pixel
        send(8'd0, 8'd0, 8'd0, 1'b0);
        send(8'd255, 8'd255, 8'd255, 1'b1);
        send(8'd255, 8'd0, 8'd128, 1'b0);
        send(8'd1, 8'd2, 8'd3, 1'b1);

        // Gain 2.0: 127 stays in range, 128 overflows and normalizes
        settle(16'd512, 3'd3);
        send(8'd200, 8'd100, 8'd50, 1'b0);
        send(8'd127, 8'd64, 8'd1, 1'b0);
        send(8'd128, 8'd64, 8'd1, 1'b1);

        // 128 * 510 hits the knee exactly: scaled, not normalized
        settle(16'd510, 3'd4);
        send(8'd128, 8'd64, 8'd0, 1'b0);
        send(8'd129, 8'd64, 8'd0, 1'b1);

        // Zero gain blacks out the pixel
        settle(16'd0, 3'd3);
        send(8'd255, 8'd128, 8'd7, 1'b0);

        // Largest gain: even a single count normalizes
        settle(16'd65535, 3'd3);
        send(8'd1, 8'd0, 8'd0, 1'b0);
        send(8'd0, 8'd0, 8'd0, 1'b1);
        send(8'd3, 8'd2, 8'd1, 1'b0);

        // Fewer than three bytes per pixel: pass through untouched
        settle(16'd65535, 3'd0);
        send(8'd255, 8'd1, 8'd254, 1'b0);
        settle(16'd65535, 3'd1);
        send(8'd17, 8'd34, 8'd51, 1'b1);
        settle(16'd65535, 3'd2);
        send(8'd200, 8'd100, 8'd50, 1'b0);

        // Out-of-range byte counts behave as three or more
        settle(16'd384, 3'd5);
        send(8'd200, 8'd100, 8'd50, 1'b1);
        send(8'd170, 8'd85, 8'd1, 1'b0);
        settle(16'd65535, 3'd6);
        send(8'd9, 8'd3, 8'd0, 1'b0);
        settle(16'd1, 3'd7);
        send(8'd255, 8'd255, 8'd255, 1'b1);

        // Random phases: receiver-heavy idling, then sender-heavy, then none
        run_phase(16'd256, 3'd3, RX_HEAVY, 1'b0);
        run_phase(16'd0, 3'd4, RX_HEAVY, 1'b0);
        run_phase(16'd65535, 3'd3, RX_HEAVY, 1'b0);
        run_phase(GAIN_W'($urandom_range(65535)), 3'd5, TX_HEAVY, 1'b0);
        run_phase(16'd384, 3'd4, TX_HEAVY, 1'b0);
        run_phase(GAIN_W'($urandom_range(65535)), 3'd2, TX_HEAVY, 1'b0);
        run_phase(16'd512, 3'd7, NO_IDLE, 1'b1);
        run_phase(GAIN_W'($urandom_range(1023)), 3'd6, NO_IDLE, 1'b0);
        run_phase(16'd300, 3'd0, NO_IDLE, 1'b1);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
